/* rtl/core/cvwm_pkg.sv */
// Package: shared types and constants of the cell voltage window monitor.
`timescale 1ns / 1ps
`default_nettype none

package cvwm_pkg;

  localparam int unsigned CELLS    = 8;
  localparam int unsigned MvW      = 16;
  localparam int unsigned TotalW   = 20;
  localparam int unsigned TickW    = 32;
  localparam int unsigned CellW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  localparam logic [MvW-1:0]    UnderLimitRst  = 16'd3000;
  localparam logic [MvW-1:0]    OverLimitRst   = 16'd4200;
  localparam logic [MvW-1:0]    WarnLevelRst   = 16'd3300;
  localparam logic [MvW-1:0]    FirstStageRst  = 16'd3400;
  localparam logic [MvW-1:0]    SecondStageRst = 16'd3200;
  localparam logic [TotalW-1:0] MinTotalRst    = 20'd18000;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFault = 2'd1,
    StUnder = 2'd2,
    StOver  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUnderLimit  = 3'd0,
    CfgOverLimit   = 3'd1,
    CfgWarnLevel   = 3'd2,
    CfgFirstStage  = 3'd3,
    CfgSecondStage = 3'd4,
    CfgMinTotal    = 3'd5,
    CfgCharger     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [MvW-1:0]    under_limit;
    logic [MvW-1:0]    over_limit;
    logic [MvW-1:0]    warn_level;
    logic [MvW-1:0]    first_stage;
    logic [MvW-1:0]    second_stage;
    logic [TotalW-1:0] min_total;
    logic              charger;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [CELLS-1:0] cell_sel;
    logic [MvW-1:0]   voltage;
    logic             last;
    logic             fault;
    logic             syserr;
    logic [TickW-1:0] now;
    logic             is_under;
    logic             is_over;
    logic             below_warn;
    logic             below_first;
    logic             below_second;
  } cls_t;

  typedef struct packed {
    status_e           status;
    logic [TotalW-1:0] total;
    logic              cell_under;
    logic              cell_over;
    logic              mon_fault;
    logic              warn;
    logic              s1_hit;
    logic              s2_hit;
    logic [TickW-1:0]  s1_time;
    logic [TickW-1:0]  s2_time;
    logic              done;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/cvwm_front.sv */
// Front end: accepts samples, compares them against the limits, queues them.
`timescale 1ns / 1ps
`default_nettype none

module cvwm_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire cvwm_pkg::cfg_t              cfg_i,
  input  wire logic                        push,
  output      logic                        full,
  input  wire logic [cvwm_pkg::CellW-1:0]  cell_index_i,
  input  wire logic [cvwm_pkg::MvW-1:0]    voltage_mv_i,
  input  wire logic                        last_cell_i,
  input  wire logic                        read_fault_i,
  input  wire logic                        system_error_i,
  input  wire logic [cvwm_pkg::TickW-1:0]  now_ms_i,
  input  wire logic                        take_i,
  output      logic                        q_valid_o,
  output      cvwm_pkg::cls_t              q_item_o
);

  cvwm_pkg::cls_t cls;
  cvwm_pkg::cls_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           acc;
  logic           deq;

  always_comb begin
    for (int i = 0; i < cvwm_pkg::CELLS; i++) begin
      cls.cell_sel[i] = (32'(cell_index_i) == 32'(i));
    end
    cls.voltage      = voltage_mv_i;
    cls.last         = last_cell_i;
    cls.fault        = read_fault_i;
    cls.syserr       = system_error_i;
    cls.now          = now_ms_i;
    cls.is_under     = voltage_mv_i <= cfg_i.under_limit;
    cls.is_over      = voltage_mv_i >= cfg_i.over_limit;
    cls.below_warn   = voltage_mv_i <= cfg_i.warn_level;
    cls.below_first  = voltage_mv_i < cfg_i.first_stage;
    cls.below_second = voltage_mv_i < cfg_i.second_stage;
  end

  assign full      = (cnt_q == 2'd2);
  assign acc       = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign deq       = take_i && q_valid_o;
  assign q_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = acc ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = deq ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(acc) - 2'(deq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cvwm_back.sv */
// Back end: run state, cell flags, stage latches and the result queue.
`timescale 1ns / 1ps
`default_nettype none

module cvwm_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cvwm_pkg::cfg_t cfg_i,
  input  wire logic           in_valid_i,
  input  wire cvwm_pkg::cls_t item_i,
  output      logic           take_o,
  input  wire logic           pop,
  output      logic           empty,
  output      cvwm_pkg::res_t res_o
);

  logic [cvwm_pkg::CELLS-1:0]  under_q, under_d;
  logic [cvwm_pkg::CELLS-1:0]  over_q, over_d;
  logic                        fault_q, fault_d;
  logic                        warn_q, warn_d;
  logic                        s1_q, s1_d;
  logic                        s2_q, s2_d;
  logic [cvwm_pkg::TickW-1:0]  t1_q, t1_d;
  logic [cvwm_pkg::TickW-1:0]  t2_q, t2_d;
  logic [cvwm_pkg::TotalW-1:0] total_q, total_d;
  cvwm_pkg::status_e           status_q, status_d;
  logic                        open_q, open_d;
  logic [cvwm_pkg::TotalW:0]   sum;
  logic                        done;
  cvwm_pkg::res_t              res;

  cvwm_pkg::res_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic           out_full;
  logic           deq;

  assign out_full = (cnt_q == 2'd2);
  assign take_o   = in_valid_i && !out_full;
  assign empty    = (cnt_q == 2'd0);
  assign deq      = pop && !empty;
  assign res_o    = mem_q[rd_ptr_q];

  always_comb begin
    under_d  = under_q;
    over_d   = over_q;
    fault_d  = fault_q;
    warn_d   = warn_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    t1_d     = t1_q;
    t2_d     = t2_q;
    total_d  = open_q ? total_q : '0;
    status_d = open_q ? status_q : cvwm_pkg::StOk;
    sum      = '0;
    done     = 1'b0;
    if (item_i.fault) begin
      fault_d  = 1'b1;
      status_d = cvwm_pkg::StFault;
      total_d  = '0;
      done     = 1'b1;
    end else begin
      fault_d = 1'b0;
      if (!s1_q && item_i.below_first) begin
        s1_d = 1'b1;
        t1_d = item_i.now;
      end else if (s1_q && !s2_q && item_i.below_second) begin
        s2_d = 1'b1;
        t2_d = item_i.now;
      end
      if (item_i.is_under) begin
        if (!cfg_i.charger) begin
          status_d = cvwm_pkg::StUnder;
          under_d  = under_q | item_i.cell_sel;
        end
      end else if (item_i.is_over) begin
        if (!cfg_i.charger) begin
          status_d = cvwm_pkg::StOver;
          over_d   = over_q | item_i.cell_sel;
        end
      end else begin
        if (item_i.below_warn) begin
          warn_d = 1'b1;
        end
        if (!item_i.syserr) begin
          under_d = under_q & ~item_i.cell_sel;
          over_d  = over_q & ~item_i.cell_sel;
        end
      end
      sum     = {1'b0, total_d} + (cvwm_pkg::TotalW + 1)'(item_i.voltage);
      total_d = sum[cvwm_pkg::TotalW] ? '1 : sum[cvwm_pkg::TotalW-1:0];
      done    = item_i.last;
      if (item_i.last && (total_d < cfg_i.min_total)) begin
        status_d = cvwm_pkg::StUnder;
      end
    end
    open_d = !done;

    res.status     = status_d;
    res.total      = total_d;
    res.cell_under = |(under_d & item_i.cell_sel);
    res.cell_over  = |(over_d & item_i.cell_sel);
    res.mon_fault  = fault_d;
    res.warn       = warn_d;
    res.s1_hit     = s1_d;
    res.s2_hit     = s2_d;
    res.s1_time    = t1_d;
    res.s2_time    = t2_d;
    res.done       = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      under_q  <= '0;
      over_q   <= '0;
      fault_q  <= 1'b0;
      warn_q   <= 1'b0;
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
      t1_q     <= '0;
      t2_q     <= '0;
      total_q  <= '0;
      status_q <= cvwm_pkg::StOk;
      open_q   <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (take_o) begin
        under_q  <= under_d;
        over_q   <= over_d;
        fault_q  <= fault_d;
        warn_q   <= warn_d;
        s1_q     <= s1_d;
        s2_q     <= s2_d;
        t1_q     <= t1_d;
        t2_q     <= t2_d;
        total_q  <= total_d;
        status_q <= status_d;
        open_q   <= open_d;
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(take_o) - 2'(deq);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/cell_voltage_window_monitor.sv */
// Top level: cell voltage window monitor with config registers and checks.
//
// Usage:
//   Samples enter through push/full: one item per cell sample, accepted when
//   push is high and full is low. A pack read is a run of items ending with
//   last_cell_i or read_fault_i set. Results leave through empty/pop: the
//   oldest result sits on the output ports while empty is low and is taken
//   when pop is high. Exactly one result comes out per item, in order.
//   Limits and charger mode are written through cfg_we_i/cfg_idx_i/
//   cfg_data_i while no item is in flight; index 7 is ignored.
//   Path: an accepted item is written to the front queue, taken by the back
//   end when the result queue has room, and its result registered there.
//   Throughput: one item per cycle while the result queue has room; the
//   limit compares and the saturating add are combinational.
//   Reset clears all cell flags, latches, timestamps, run total and status,
//   and loads the default limits; the next item opens a new run.
//   When the receiver stalls, the two-entry result queue fills, then the
//   two-entry front queue fills and full rises; no item is lost.
`timescale 1ns / 1ps
`default_nettype none

module cell_voltage_window_monitor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cvwm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [cvwm_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic [cvwm_pkg::CellW-1:0]    cell_index_i,
  input  wire logic [cvwm_pkg::MvW-1:0]      voltage_mv_i,
  input  wire logic                          last_cell_i,
  input  wire logic                          read_fault_i,
  input  wire logic                          system_error_i,
  input  wire logic [cvwm_pkg::TickW-1:0]    now_ms_i,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic [1:0]                    pack_status_o,
  output      logic [cvwm_pkg::TotalW-1:0]   total_mv_o,
  output      logic                          cell_under_o,
  output      logic                          cell_over_o,
  output      logic                          monitor_fault_o,
  output      logic                          warning_latched_o,
  output      logic                          first_stage_hit_o,
  output      logic                          second_stage_hit_o,
  output      logic [cvwm_pkg::TickW-1:0]    first_stage_time_o,
  output      logic [cvwm_pkg::TickW-1:0]    second_stage_time_o,
  output      logic                          run_done_o
);

  cvwm_pkg::cfg_t cfg_q;
  cvwm_pkg::cls_t q_item;
  cvwm_pkg::res_t res;
  logic           q_valid;
  logic           take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.under_limit  <= cvwm_pkg::UnderLimitRst;
      cfg_q.over_limit   <= cvwm_pkg::OverLimitRst;
      cfg_q.warn_level   <= cvwm_pkg::WarnLevelRst;
      cfg_q.first_stage  <= cvwm_pkg::FirstStageRst;
      cfg_q.second_stage <= cvwm_pkg::SecondStageRst;
      cfg_q.min_total    <= cvwm_pkg::MinTotalRst;
      cfg_q.charger      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cvwm_pkg::cfg_idx_e'(cfg_idx_i))
        cvwm_pkg::CfgUnderLimit:  cfg_q.under_limit  <= cfg_data_i[cvwm_pkg::MvW-1:0];
        cvwm_pkg::CfgOverLimit:   cfg_q.over_limit   <= cfg_data_i[cvwm_pkg::MvW-1:0];
        cvwm_pkg::CfgWarnLevel:   cfg_q.warn_level   <= cfg_data_i[cvwm_pkg::MvW-1:0];
        cvwm_pkg::CfgFirstStage:  cfg_q.first_stage  <= cfg_data_i[cvwm_pkg::MvW-1:0];
        cvwm_pkg::CfgSecondStage: cfg_q.second_stage <= cfg_data_i[cvwm_pkg::MvW-1:0];
        cvwm_pkg::CfgMinTotal:    cfg_q.min_total    <= cfg_data_i[cvwm_pkg::TotalW-1:0];
        cvwm_pkg::CfgCharger:     cfg_q.charger      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cvwm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push           (push),
    .full           (full),
    .cell_index_i   (cell_index_i),
    .voltage_mv_i   (voltage_mv_i),
    .last_cell_i    (last_cell_i),
    .read_fault_i   (read_fault_i),
    .system_error_i (system_error_i),
    .now_ms_i       (now_ms_i),
    .take_i         (take),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item)
  );

  cvwm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (q_valid),
    .item_i     (q_item),
    .take_o     (take),
    .pop        (pop),
    .empty      (empty),
    .res_o      (res)
  );

  assign pack_status_o       = res.status;
  assign total_mv_o          = res.total;
  assign cell_under_o        = res.cell_under;
  assign cell_over_o         = res.cell_over;
  assign monitor_fault_o     = res.mon_fault;
  assign warning_latched_o   = res.warn;
  assign first_stage_hit_o   = res.s1_hit;
  assign second_stage_hit_o  = res.s2_hit;
  assign first_stage_time_o  = res.s1_time;
  assign second_stage_time_o = res.s2_time;
  assign run_done_o          = res.done;

`ifndef SYNTH
  a_fault_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && monitor_fault_o) |->
      (run_done_o && pack_status_o == cvwm_pkg::StFault && total_mv_o == '0))
    else $error("fault item without fault status");

  a_stage_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && second_stage_hit_o) |-> first_stage_hit_o)
    else $error("second stage latched without first");

  a_full_implies_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("front queue full while result queue is empty");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench: cell voltage window monitor driven through its queues and checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import cvwm_pkg::*;

  localparam int unsigned          LimitCycles   = 200000;
  localparam int unsigned          ItemsPerPhase = 100;
  localparam int unsigned          NumPhases     = 8;
  localparam int unsigned          HoldCycles    = 200;
  localparam int unsigned          MaxReports    = 40;
  localparam logic [CfgIdxW-1:0]   CfgNone       = 3'd7;
  localparam logic [TotalW-1:0]    TotalMax      = {TotalW{1'b1}};

  typedef struct packed {
    logic [CellW-1:0] cidx;
    logic [MvW-1:0]   volt;
    logic             last;
    logic             rfault;
    logic             syserr;
    logic [TickW-1:0] now;
  } sample_t;

  class pack_scoreboard;
    logic [MvW-1:0]    under_lim, over_lim, warn_lvl, s1_lvl, s2_lvl;
    logic [TotalW-1:0] min_total;
    logic              charger;
    logic [CELLS-1:0]  under_f, over_f;
    logic              fault_f, warn_f, s1, s2, run_open;
    logic [TickW-1:0]  s1_tick, s2_tick;
    logic [TotalW-1:0] total;
    status_e           status;
    res_t              expected_q[$];
    int unsigned       errors;

    function new();
      under_lim = UnderLimitRst;
      over_lim  = OverLimitRst;
      warn_lvl  = WarnLevelRst;
      s1_lvl    = FirstStageRst;
      s2_lvl    = SecondStageRst;
      min_total = MinTotalRst;
      charger   = 1'b0;
      under_f   = '0;
      over_f    = '0;
      fault_f   = 1'b0;
      warn_f    = 1'b0;
      s1        = 1'b0;
      s2        = 1'b0;
      run_open  = 1'b0;
      s1_tick   = '0;
      s2_tick   = '0;
      total     = '0;
      status    = StOk;
      errors    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgUnderLimit:  under_lim = data[MvW-1:0];
        CfgOverLimit:   over_lim  = data[MvW-1:0];
        CfgWarnLevel:   warn_lvl  = data[MvW-1:0];
        CfgFirstStage:  s1_lvl    = data[MvW-1:0];
        CfgSecondStage: s2_lvl    = data[MvW-1:0];
        CfgMinTotal:    min_total = data[TotalW-1:0];
        CfgCharger:     charger   = data[0];
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t s);
      res_t            r;
      logic [TotalW:0] sum;
      r = '0;
      if (!run_open) begin
        total    = '0;
        status   = StOk;
        run_open = 1'b1;
      end
      if (s.rfault) begin
        fault_f = 1'b1;
        status  = StFault;
        total   = '0;
        r.done  = 1'b1;
      end else begin
        fault_f = 1'b0;
        if (!s1 && s.volt < s1_lvl) begin
          s1      = 1'b1;
          s1_tick = s.now;
        end else if (s1 && !s2 && s.volt < s2_lvl) begin
          s2      = 1'b1;
          s2_tick = s.now;
        end
        if (s.volt <= under_lim) begin
          if (!charger) begin
            status           = StUnder;
            under_f[s.cidx]  = 1'b1;
          end
        end else if (s.volt >= over_lim) begin
          if (!charger) begin
            status          = StOver;
            over_f[s.cidx]  = 1'b1;
          end
        end else begin
          if (s.volt <= warn_lvl) warn_f = 1'b1;
          if (!s.syserr) begin
            under_f[s.cidx] = 1'b0;
            over_f[s.cidx]  = 1'b0;
          end
        end
        sum   = {1'b0, total} + {{(TotalW + 1 - MvW){1'b0}}, s.volt};
        total = (sum > {1'b0, TotalMax}) ? TotalMax : sum[TotalW-1:0];
        r.done = s.last;
        if (s.last && total < min_total) status = StUnder;
      end
      if (r.done) run_open = 1'b0;
      r.status     = status;
      r.total      = total;
      r.cell_under = under_f[s.cidx];
      r.cell_over  = over_f[s.cidx];
      r.mon_fault  = fault_f;
      r.warn       = warn_f;
      r.s1_hit     = s1;
      r.s2_hit     = s2;
      r.s1_time    = s1_tick;
      r.s2_time    = s2_tick;
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [TickW-1:0] want, logic [TickW-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected result, expected none actual status %0d total %0h",
                   $time, got.status, got.total);
        return;
      end
      want = expected_q.pop_front();
      cmp("pack_status",       TickW'(want.status),     TickW'(got.status));
      cmp("total_mv",          TickW'(want.total),      TickW'(got.total));
      cmp("cell_under",        TickW'(want.cell_under), TickW'(got.cell_under));
      cmp("cell_over",         TickW'(want.cell_over),  TickW'(got.cell_over));
      cmp("monitor_fault",     TickW'(want.mon_fault),  TickW'(got.mon_fault));
      cmp("warning_latched",   TickW'(want.warn),       TickW'(got.warn));
      cmp("first_stage_hit",   TickW'(want.s1_hit),     TickW'(got.s1_hit));
      cmp("second_stage_hit",  TickW'(want.s2_hit),     TickW'(got.s2_hit));
      cmp("first_stage_time",  want.s1_time,            got.s1_time);
      cmp("second_stage_time", want.s2_time,            got.s2_time);
      cmp("run_done",          TickW'(want.done),       TickW'(got.done));
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i      = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                push           = 1'b0;
  logic                full;
  logic [CellW-1:0]    cell_index_i   = '0;
  logic [MvW-1:0]      voltage_mv_i   = '0;
  logic                last_cell_i    = 1'b0;
  logic                read_fault_i   = 1'b0;
  logic                system_error_i = 1'b0;
  logic [TickW-1:0]    now_ms_i       = '0;
  logic                empty;
  logic                pop            = 1'b0;
  logic [1:0]          pack_status_o;
  logic [TotalW-1:0]   total_mv_o;
  logic                cell_under_o, cell_over_o, monitor_fault_o, warning_latched_o;
  logic                first_stage_hit_o, second_stage_hit_o, run_done_o;
  logic [TickW-1:0]    first_stage_time_o, second_stage_time_o;

  pack_scoreboard sb = new();

  int unsigned src_idle = 6;
  int unsigned dst_idle = 52;
  logic        hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned cycles   = 0;

  cell_voltage_window_monitor dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .push                (push),
    .full                (full),
    .cell_index_i        (cell_index_i),
    .voltage_mv_i        (voltage_mv_i),
    .last_cell_i         (last_cell_i),
    .read_fault_i        (read_fault_i),
    .system_error_i      (system_error_i),
    .now_ms_i            (now_ms_i),
    .empty               (empty),
    .pop                 (pop),
    .pack_status_o       (pack_status_o),
    .total_mv_o          (total_mv_o),
    .cell_under_o        (cell_under_o),
    .cell_over_o         (cell_over_o),
    .monitor_fault_o     (monitor_fault_o),
    .warning_latched_o   (warning_latched_o),
    .first_stage_hit_o   (first_stage_hit_o),
    .second_stage_hit_o  (second_stage_hit_o),
    .first_stage_time_o  (first_stage_time_o),
    .second_stage_time_o (second_stage_time_o),
    .run_done_o          (run_done_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LimitCycles) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: check on accept, then pick pop for the next cycle
  initial begin
    res_t got;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.status     = status_e'(pack_status_o);
        got.total      = total_mv_o;
        got.cell_under = cell_under_o;
        got.cell_over  = cell_over_o;
        got.mon_fault  = monitor_fault_o;
        got.warn       = warning_latched_o;
        got.s1_hit     = first_stage_hit_o;
        got.s2_hit     = second_stage_hit_o;
        got.s1_time    = first_stage_time_o;
        got.s2_time    = second_stage_time_o;
        got.done       = run_done_o;
        sb.check_result(got);
      end
      if (hold_cnt != 0) begin
        hold_cnt = hold_cnt - 1;
        pop <= 1'b0;
      end else if (hold_req) begin
        hold_req <= 1'b0;
        hold_cnt = HoldCycles;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= dst_idle);
      end
    end
  end

  task automatic send_item(input sample_t s);
    while ($urandom_range(99) < src_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    cell_index_i   <= s.cidx;
    voltage_mv_i   <= s.volt;
    last_cell_i    <= s.last;
    read_fault_i   <= s.rfault;
    system_error_i <= s.syserr;
    now_ms_i       <= s.now;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_sample(s);
  endtask

  task automatic send_sample(input logic [CellW-1:0] cidx, input logic [MvW-1:0] volt,
                             input logic last, input logic rfault, input logic syserr,
                             input logic [TickW-1:0] now);
    sample_t s;
    s = '{cidx: cidx, volt: volt, last: last, rfault: rfault, syserr: syserr, now: now};
    send_item(s);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic load_phase_config(input int unsigned phase);
    logic [CfgDataW-1:0] u, o, w, f, s, m, c;
    case (phase)
      1: begin
        u = '0; o = '0; w = '0; f = '0; s = '0; m = '0; c = '0;
      end
      2: begin
        u = '1; o = '1; w = '1; f = '1; s = '1; m = '1; c = '1;
      end
      3, 4, 6: begin
        u = CfgDataW'($urandom_range(3200, 2500));
        o = CfgDataW'($urandom_range(4400, 3900));
        w = CfgDataW'($urandom_range(3600, 3000));
        f = CfgDataW'($urandom_range(3800, 3100));
        s = CfgDataW'($urandom_range(3400, 2800));
        m = CfgDataW'($urandom_range(30000, 5000));
        c = (phase == 4) ? 20'd1 : 20'd0;
      end
      default: begin
        u = CfgDataW'($urandom()); o = CfgDataW'($urandom());
        w = CfgDataW'($urandom()); f = CfgDataW'($urandom());
        s = CfgDataW'($urandom()); m = CfgDataW'($urandom());
        c = CfgDataW'($urandom());
      end
    endcase
    write_reg(CfgUnderLimit, u);
    write_reg(CfgOverLimit, o);
    write_reg(CfgWarnLevel, w);
    write_reg(CfgFirstStage, f);
    write_reg(CfgSecondStage, s);
    write_reg(CfgMinTotal, m);
    write_reg(CfgCharger, c);
    if (phase == 6) write_reg(CfgNone, CfgDataW'($urandom()));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // default limits: under 3000, over 4200, warn 3300, stages 3400/3200, min total 18000
  task automatic run_directed();
    send_sample(3'd0, 16'd3100,  1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF); // below both stages: first only
    send_sample(3'd1, 16'd3350,  1'b0, 1'b0, 1'b0, 32'h0000_0001); // in band above warn
    send_sample(3'd2, 16'd3100,  1'b0, 1'b0, 1'b0, 32'h8000_0000); // second stage later
    send_sample(3'd3, 16'd0,     1'b0, 1'b0, 1'b0, 32'h0000_0000);
    send_sample(3'd4, 16'hFFFF,  1'b0, 1'b0, 1'b0, 32'h1234_5678);
    send_sample(3'd5, 16'd3000,  1'b0, 1'b0, 1'b0, 32'h0000_0002); // at under limit
    send_sample(3'd6, 16'd4200,  1'b0, 1'b0, 1'b0, 32'h0000_0003); // at over limit
    send_sample(3'd7, 16'd3500,  1'b1, 1'b0, 1'b0, 32'h0000_0004);
    send_sample(3'd3, 16'd3500,  1'b0, 1'b0, 1'b1, 32'h0000_0005); // system error keeps flags
    send_sample(3'd3, 16'd3500,  1'b0, 1'b0, 1'b0, 32'h0000_0006);
    send_sample(3'd4, 16'd3301,  1'b0, 1'b0, 1'b0, 32'h0000_0007);
    send_sample(3'd4, 16'd3300,  1'b0, 1'b0, 1'b0, 32'h0000_0008); // at warn level; warning already latched by cell 0
    send_sample(3'd6, 16'd4199,  1'b0, 1'b0, 1'b0, 32'h0000_0009);
    send_sample(3'd5, 16'd1000,  1'b1, 1'b0, 1'b0, 32'h0000_000A);
    send_sample(3'd0, 16'hA5A5,  1'b0, 1'b1, 1'b0, 32'h0000_000B); // read fault mid run
    send_sample(3'd0, 16'd4000,  1'b1, 1'b0, 1'b0, 32'h0000_000C); // total under minimum
    send_sample(3'd1, 16'd3700,  1'b0, 1'b0, 1'b1, 32'h0000_000D);
    send_sample(3'd2, 16'h5A5A,  1'b1, 1'b1, 1'b1, 32'h0000_000E); // fault on last cell
    send_sample(3'd0, 16'd3001,  1'b1, 1'b0, 1'b0, 32'h0000_000F);
  endtask

  function automatic logic [MvW-1:0] pick_voltage();
    logic [MvW-1:0] lvl;
    int unsigned    r;
    r = $urandom_range(99);
    if (r < 40) begin
      case ($urandom_range(4))
        0:       lvl = sb.under_lim;
        1:       lvl = sb.over_lim;
        2:       lvl = sb.warn_lvl;
        3:       lvl = sb.s1_lvl;
        default: lvl = sb.s2_lvl;
      endcase
      return lvl + MvW'($urandom_range(2)) - MvW'(1);
    end
    if (r < 70) return MvW'($urandom_range(sb.over_lim, sb.under_lim));
    return MvW'($urandom());
  endfunction

  task automatic send_run(output int unsigned n);
    sample_t     s;
    int unsigned len, r;
    logic        flood;
    n = 0;
    r = $urandom_range(99);
    if (r < 10) begin
      s.cidx   = CellW'($urandom());
      s.volt   = MvW'($urandom());
      s.last   = 1'($urandom_range(1));
      s.rfault = ($urandom_range(3) == 0);
      s.syserr = 1'($urandom_range(1));
      s.now    = $urandom();
      send_item(s);
      n = 1;
      return;
    end
    flood = (r < 16);
    len = flood ? $urandom_range(20, 17) : $urandom_range(8, 1);
    for (int unsigned i = 0; i < len; i++) begin
      s.cidx   = CellW'(i);
      s.volt   = flood ? MvW'($urandom_range(65535, 60000)) : pick_voltage();
      s.rfault = ($urandom_range(24) == 0);
      s.last   = (i == len - 1) || (s.rfault && $urandom_range(1) == 1);
      s.syserr = ($urandom_range(3) == 0);
      s.now    = $urandom();
      send_item(s);
      n++;
      if (s.rfault) break;
    end
  endtask

  initial begin
    int unsigned sent, n;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase < 3) begin
        src_idle = 6;
        dst_idle = 52;
      end else if (phase < 6) begin
        src_idle = 52;
        dst_idle = 6;
      end else begin
        src_idle = 0;
        dst_idle = 0;
      end
      if (phase != 0) begin
        drain();
        load_phase_config(phase);
      end else begin
        run_directed();
      end
      if (phase == 1) hold_req <= 1'b1;
      sent = 0;
      while (sent < ItemsPerPhase) begin
        send_run(n);
        sent += n;
      end
    end
    drain();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
